FILE: src/first_fit_heap_allocator_top_macros.svh
// Assertion macros shared by the allocator RTL.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define FFHA_ASSERT_IMPLY(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("allocator check failed");
`define FFHA_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("allocator check failed");
`else
`define FFHA_ASSERT_IMPLY(lbl, pre, post)
`define FFHA_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

FILE: src/ffha_pkg.sv
// Shared constants, types and codes of the first-fit heap allocator.
// No dependencies.
package ffha_pkg;

    localparam int HEAP_BYTES   = 64 * 1024;
    localparam int HEADER_BYTES = 16;
    localparam int ALIGN_BYTES  = 8;
    localparam int GRAIN_BYTES  = 8;
    localparam int GRAIN_SH     = $clog2(GRAIN_BYTES);
    localparam int DEPTH        = HEAP_BYTES / GRAIN_BYTES;
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int ADDR_W       = $clog2(HEAP_BYTES) + 1;
    localparam int SUM_W        = ADDR_W + 1;
    localparam int SIZE_W       = 16;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [SUM_W-1:0]  sum_t;
    typedef logic [SIZE_W-1:0] size_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NOMEM   = 2'd1,
        ST_BADADDR = 2'd2
    } status_t;

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_WALK,
        S_SPLIT,
        S_FNEXT,
        S_FMERGE,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic  used;
        size_t size;
    } hdr_t;

    typedef struct packed {
        logic rd_en;
        idx_t rd_idx;
        logic wr_en;
        idx_t wr_idx;
        hdr_t wr_data;
    } mem_req_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] payload_address;
        logic [15:0] granted_bytes;
    } res_t;

endpackage

FILE: src/ffha_hdr_ram.sv
// Block header store: one header per 8-byte heap grain, one read and one write port.
// Depends on ffha_pkg.
module ffha_hdr_ram
    import ffha_pkg::*;
(
    input  logic     clk,
    input  mem_req_t mem,
    output hdr_t     rd_data
);

    hdr_t store_mem [DEPTH];
    hdr_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem.wr_en)
        begin
            store_mem[mem.wr_idx] <= mem.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem.rd_en)
        begin
            rd_data_reg <= store_mem[mem.rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/ffha_ctrl.sv
// Sequencer of the allocator: walks the header chain with one shared adder.
// Depends on ffha_pkg and first_fit_heap_allocator_top_macros.svh.
`include "first_fit_heap_allocator_top_macros.svh"
module ffha_ctrl
    import ffha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        kind,
    input  logic [15:0] request_bytes,
    input  logic [15:0] address,
    output logic        req_ready,
    input  hdr_t        rd_data,
    output mem_req_t    mem,
    input  logic        res_ready,
    output logic        res_valid,
    output res_t        res
);

    state_t state_reg, state_next;
    kind_t  kind_reg, kind_next;
    size_t  want_reg, want_next;
    logic [15:0] addr_reg, addr_next;
    addr_t  at_reg, at_next;
    idx_t   prev_idx_reg, prev_idx_next;
    size_t  prev_size_reg, prev_size_next;
    logic   prev_used_reg, prev_used_next;
    logic   has_prev_reg, has_prev_next;
    size_t  cur_size_reg, cur_size_next;
    logic   nx_ok_reg, nx_ok_next;
    size_t  merged_reg, merged_next;
    res_t   res_reg, res_next;

    addr_t  want_round;
    logic   at_end;
    logic   fits;
    logic   exact;
    logic   split_ok;
    addr_t  op_a;
    addr_t  op_b;
    sum_t   sum;
    logic   sum_in_heap;
    sum_t   pay_full;
    size_t  rest_size;
    size_t  merged;

    assign want_round = (addr_t'(want_reg) + addr_t'(ALIGN_BYTES - 1))
                        & ~addr_t'(ALIGN_BYTES - 1);
    assign at_end     = at_reg >= addr_t'(HEAP_BYTES);
    assign fits       = !rd_data.used && (rd_data.size >= want_reg);
    assign exact      = rd_data.size == want_reg;
    assign split_ok   = sum_t'(rd_data.size) > (sum_t'(want_round) + sum_t'(HEADER_BYTES));
    assign pay_full   = sum_t'(at_reg) + sum_t'(HEADER_BYTES);
    assign rest_size  = SIZE_W'(sum_t'(rd_data.size) - sum_t'(want_round)
                                - sum_t'(HEADER_BYTES));
    assign merged     = (nx_ok_reg && !rd_data.used) ? sum[SIZE_W-1:0] : cur_size_reg;

    always_comb
    begin
        op_a = at_reg;
        op_b = addr_t'(rd_data.size);
        unique case (state_reg)
            S_WALK:
            begin
                if (kind_reg == KIND_ALLOC && fits && !exact)
                begin
                    op_b = want_round;
                end
            end
            S_FNEXT:
            begin
                op_a = addr_t'(cur_size_reg);
            end
            S_FMERGE:
            begin
                op_a = addr_t'(prev_size_reg);
                op_b = addr_t'(merged_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign sum         = sum_t'(op_a) + sum_t'(op_b) + sum_t'(HEADER_BYTES);
    assign sum_in_heap = sum < sum_t'(HEAP_BYTES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            has_prev_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            has_prev_reg <= has_prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        want_reg      <= want_next;
        addr_reg      <= addr_next;
        at_reg        <= at_next;
        prev_idx_reg  <= prev_idx_next;
        prev_size_reg <= prev_size_next;
        prev_used_reg <= prev_used_next;
        cur_size_reg  <= cur_size_next;
        nx_ok_reg     <= nx_ok_next;
        merged_reg    <= merged_next;
        res_reg       <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        want_next      = want_reg;
        addr_next      = addr_reg;
        at_next        = at_reg;
        prev_idx_next  = prev_idx_reg;
        prev_size_next = prev_size_reg;
        prev_used_next = prev_used_reg;
        has_prev_next  = has_prev_reg;
        cur_size_next  = cur_size_reg;
        nx_ok_next     = nx_ok_reg;
        merged_next    = merged_reg;
        res_next       = res_reg;
        mem            = '0;
        req_ready      = 1'b0;
        res_valid      = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                mem.wr_en        = 1'b1;
                mem.wr_idx       = '0;
                mem.wr_data.used = 1'b0;
                mem.wr_data.size = SIZE_W'(HEAP_BYTES - HEADER_BYTES);
                state_next       = S_IDLE;
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    kind_next     = kind_t'(kind);
                    want_next     = request_bytes;
                    addr_next     = address;
                    at_next       = '0;
                    has_prev_next = 1'b0;
                    mem.rd_en     = 1'b1;
                    mem.rd_idx    = '0;
                    state_next    = S_WALK;
                end
            end
            S_WALK:
            begin
                if (at_end)
                begin
                    res_next.status          = (kind_reg == KIND_FREE) ? ST_BADADDR : ST_NOMEM;
                    res_next.payload_address = '0;
                    res_next.granted_bytes   = '0;
                    state_next               = S_RESULT;
                end
                else if (kind_reg == KIND_ALLOC)
                begin
                    if (fits)
                    begin
                        res_next.status          = ST_NOMEM;
                        res_next.payload_address = '0;
                        res_next.granted_bytes   = '0;
                        state_next               = S_RESULT;
                        if (exact)
                        begin
                            mem.wr_en                = 1'b1;
                            mem.wr_idx               = at_reg[GRAIN_SH +: IDX_W];
                            mem.wr_data.used         = 1'b1;
                            mem.wr_data.size         = rd_data.size;
                            res_next.status          = ST_DONE;
                            res_next.payload_address = pay_full[15:0];
                            res_next.granted_bytes   = rd_data.size;
                        end
                        else if (split_ok && sum_in_heap)
                        begin
                            mem.wr_en                = 1'b1;
                            mem.wr_idx               = sum[GRAIN_SH +: IDX_W];
                            mem.wr_data.used         = 1'b0;
                            mem.wr_data.size         = rest_size;
                            cur_size_next            = want_round[SIZE_W-1:0];
                            res_next.status          = ST_DONE;
                            res_next.payload_address = pay_full[15:0];
                            res_next.granted_bytes   = want_round[15:0];
                            state_next               = S_SPLIT;
                        end
                    end
                    else
                    begin
                        at_next    = sum[ADDR_W-1:0];
                        mem.rd_en  = sum_in_heap;
                        mem.rd_idx = sum[GRAIN_SH +: IDX_W];
                    end
                end
                else if (pay_full == sum_t'(addr_reg))
                begin
                    if (!rd_data.used)
                    begin
                        res_next.status          = ST_BADADDR;
                        res_next.payload_address = '0;
                        res_next.granted_bytes   = '0;
                        state_next               = S_RESULT;
                    end
                    else
                    begin
                        cur_size_next = rd_data.size;
                        nx_ok_next    = sum_in_heap;
                        mem.rd_en     = sum_in_heap;
                        mem.rd_idx    = sum[GRAIN_SH +: IDX_W];
                        state_next    = S_FNEXT;
                    end
                end
                else
                begin
                    prev_idx_next  = at_reg[GRAIN_SH +: IDX_W];
                    prev_size_next = rd_data.size;
                    prev_used_next = rd_data.used;
                    has_prev_next  = 1'b1;
                    at_next        = sum[ADDR_W-1:0];
                    mem.rd_en      = sum_in_heap;
                    mem.rd_idx     = sum[GRAIN_SH +: IDX_W];
                end
            end
            S_SPLIT:
            begin
                mem.wr_en        = 1'b1;
                mem.wr_idx       = at_reg[GRAIN_SH +: IDX_W];
                mem.wr_data.used = 1'b1;
                mem.wr_data.size = cur_size_reg;
                state_next       = S_RESULT;
            end
            S_FNEXT:
            begin
                merged_next = merged;
                state_next  = S_FMERGE;
            end
            S_FMERGE:
            begin
                mem.wr_en                = 1'b1;
                mem.wr_data.used         = 1'b0;
                res_next.status          = ST_DONE;
                res_next.payload_address = '0;
                if (has_prev_reg && !prev_used_reg)
                begin
                    mem.wr_idx             = prev_idx_reg;
                    mem.wr_data.size       = sum[SIZE_W-1:0];
                    res_next.granted_bytes = sum[15:0];
                end
                else
                begin
                    mem.wr_idx             = at_reg[GRAIN_SH +: IDX_W];
                    mem.wr_data.size       = merged_reg;
                    res_next.granted_bytes = merged_reg;
                end
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    assign res = res_reg;

    `FFHA_ASSERT_NEXT(a_accept_walk, req_valid && req_ready, state_reg == S_WALK)
    `FFHA_ASSERT_IMPLY(a_walk_aligned, state_reg == S_WALK, at_reg[GRAIN_SH-1:0] == '0)
    `FFHA_ASSERT_NEXT(a_walk_forward, state_reg == S_WALK && state_next == S_WALK,
                      at_reg > $past(at_reg))
    `FFHA_ASSERT_IMPLY(a_fail_zero, res_valid && res.status != ST_DONE,
                       res.payload_address == '0 && res.granted_bytes == '0)

endmodule

FILE: src/first_fit_heap_allocator_top.sv
// Top level of the first-fit heap allocator: sequencer, header store, result register.
// Depends on ffha_pkg, ffha_ctrl, ffha_hdr_ram and the macros header.
//
// Input channel in_valid/in_stall carries one item: kind (0 allocate, 1 free),
// request_bytes and address. Output channel out_valid/out_stall carries one result
// per item: status, payload_address and granted_bytes.
// The heap is a chain of headed blocks; each request walks the chain from offset 0,
// one block header per cycle through the header store read port.
// Allocate: an accept step, the headers visited, a split step when the block is split,
// then a step that hands the result to the output register.
// Free: accept, the headers up to the named block, then next-header read, merge
// write and hand-off. The number of headers visited grows with fragmentation.
// One item is in work at a time; in_stall is high until the sequencer is idle.
// The output register frees the sequencer, so a new item is taken while a result
// waits under out_stall; the next result then waits in the sequencer.
// After reset the block writes the whole-heap free header in its init state,
// then accepts items.
`include "first_fit_heap_allocator_top_macros.svh"
module first_fit_heap_allocator_top
    import ffha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [15:0] request_bytes,
    input  logic [15:0] address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] payload_address,
    output logic [15:0] granted_bytes
);

    mem_req_t mem;
    hdr_t     rd_data;
    logic     req_ready;
    logic     res_ready;
    logic     res_valid;
    res_t     res;
    logic     out_valid_reg;
    res_t     out_res_reg;

    ffha_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (in_valid),
        .kind          (kind),
        .request_bytes (request_bytes),
        .address       (address),
        .req_ready     (req_ready),
        .rd_data       (rd_data),
        .mem           (mem),
        .res_ready     (res_ready),
        .res_valid     (res_valid),
        .res           (res)
    );

    ffha_hdr_ram u_hdr_ram (
        .clk     (clk),
        .mem     (mem),
        .rd_data (rd_data)
    );

    assign in_stall  = !req_ready;
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_res_reg.status;
    assign payload_address = out_res_reg.payload_address;
    assign granted_bytes   = out_res_reg.granted_bytes;

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for first_fit_heap_allocator_top: allocate and free items
// go through the valid/stall channels and a heap scoreboard predicts every result.
// Depends on ffha_pkg and the allocator RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ffha_pkg::*;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int QUIET_ITEMS  = 150;
    localparam int LIVE_CAP     = 40;
    localparam int DRAIN_EVERY  = 300;
    localparam int TAIL_CYCLES  = 200;

    typedef struct {
        status_t     st;
        logic [15:0] pa;
        logic [15:0] gb;
    } answer_t;

    class heap_scoreboard;
        int unsigned blk_len [HEAP_BYTES];
        bit          blk_busy [HEAP_BYTES];
        answer_t     answer_q [$];
        int unsigned live_q [$];
        int unsigned last_grant;
        int unsigned last_freed;
        int          errors;
        int          checked;
        int          n_alloc;
        int          n_free;
        int          n_nomem;
        int          n_bad;
        int          n_merge;

        function new();
            foreach (blk_len[i])
            begin
                blk_len[i]  = 0;
                blk_busy[i] = 1'b0;
            end
            blk_len[0] = HEAP_BYTES - HEADER_BYTES;
        endfunction

        function int pending();
            return answer_q.size();
        endfunction

        function int unsigned pick_free_len();
            int unsigned at;
            int unsigned lens [$];
            at = 0;
            while (at < HEAP_BYTES)
            begin
                if (!blk_busy[at])
                    lens.push_back(blk_len[at]);
                at += HEADER_BYTES + blk_len[at];
            end
            if (lens.size() == 0)
                return 65535;
            return lens[$urandom_range(0, lens.size() - 1)];
        endfunction

        function void note_item(kind_t k, int unsigned want, int unsigned addr);
            answer_t     a;
            int unsigned at;
            int unsigned prev;
            int unsigned r;
            int unsigned rest;
            int unsigned nx;
            bit          has_prev;
            a.st = ST_NOMEM;
            a.pa = '0;
            a.gb = '0;
            if (k == KIND_ALLOC)
            begin
                n_alloc++;
                at = 0;
                while (at < HEAP_BYTES)
                begin
                    if (!blk_busy[at] && blk_len[at] >= want)
                    begin
                        r = ((want + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
                        if (blk_len[at] == want)
                        begin
                            blk_busy[at] = 1'b1;
                            a.st = ST_DONE;
                            a.pa = 16'(at + HEADER_BYTES);
                            a.gb = 16'(want);
                        end
                        else if (blk_len[at] > r + HEADER_BYTES)
                        begin
                            rest = at + HEADER_BYTES + r;
                            blk_len[rest]  = blk_len[at] - r - HEADER_BYTES;
                            blk_busy[rest] = 1'b0;
                            blk_len[at]    = r;
                            blk_busy[at]   = 1'b1;
                            a.st = ST_DONE;
                            a.pa = 16'(at + HEADER_BYTES);
                            a.gb = 16'(r);
                        end
                        break;
                    end
                    at += HEADER_BYTES + blk_len[at];
                end
                if (a.st == ST_DONE)
                begin
                    last_grant = at + HEADER_BYTES;
                    live_q.push_back(last_grant);
                end
                else
                    n_nomem++;
            end
            else
            begin
                n_free++;
                at       = 0;
                prev     = 0;
                has_prev = 1'b0;
                while (at < HEAP_BYTES && at + HEADER_BYTES != addr)
                begin
                    prev     = at;
                    has_prev = 1'b1;
                    at += HEADER_BYTES + blk_len[at];
                end
                if (at >= HEAP_BYTES || !blk_busy[at])
                begin
                    a.st = ST_BADADDR;
                    n_bad++;
                end
                else
                begin
                    blk_busy[at] = 1'b0;
                    nx = at + HEADER_BYTES + blk_len[at];
                    if (nx < HEAP_BYTES && !blk_busy[nx])
                    begin
                        blk_len[at] += HEADER_BYTES + blk_len[nx];
                        n_merge++;
                    end
                    if (has_prev && !blk_busy[prev])
                    begin
                        blk_len[prev] += HEADER_BYTES + blk_len[at];
                        at = prev;
                        n_merge++;
                    end
                    a.st = ST_DONE;
                    a.gb = 16'(blk_len[at]);
                    for (int i = 0; i < live_q.size(); i++)
                    begin
                        if (live_q[i] == addr)
                        begin
                            live_q.delete(i);
                            break;
                        end
                    end
                    last_freed = addr;
                end
            end
            answer_q.push_back(a);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 20)
                $display("mismatch %0d: %s", errors, msg);
        endtask

        task check_result(logic [1:0] st, logic [15:0] pa, logic [15:0] gb);
            answer_t a;
            if (answer_q.size() == 0)
            begin
                report($sformatf("result st=%0d pa=%0d gb=%0d with no item waiting",
                                 st, pa, gb));
                return;
            end
            a = answer_q.pop_front();
            checked++;
            if (st !== a.st)
                report($sformatf("result %0d status %0d, predicted %0d", checked, st, a.st));
            if (pa !== a.pa)
                report($sformatf("result %0d payload_address %0d, predicted %0d",
                                 checked, pa, a.pa));
            if (gb !== a.gb)
                report($sformatf("result %0d granted_bytes %0d, predicted %0d",
                                 checked, gb, a.gb));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        kind = 1'b0;
    logic [15:0] request_bytes = '0;
    logic [15:0] address = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [15:0] payload_address;
    logic [15:0] granted_bytes;

    heap_scoreboard sb = new();
    bit sender_idle_on = 1'b1;
    bit sink_idle_on = 1'b1;
    int cycle_count = 0;

    first_fit_heap_allocator_top u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .request_bytes   (request_bytes),
        .address         (address),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .payload_address (payload_address),
        .granted_bytes   (granted_bytes)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, sb.pending());
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int burst;
        burst = 0;
        forever
        begin
            @(negedge clk);
            if (burst > 0)
            begin
                out_stall <= 1'b1;
                burst--;
            end
            else if (sink_idle_on && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                burst = $urandom_range(0, 2);
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(status, payload_address, granted_bytes);
    end

    task automatic send_item(kind_t k, int unsigned want, int unsigned addr);
        int gap_len;
        @(negedge clk);
        if (sender_idle_on && $urandom_range(0, 3) == 0)
        begin
            gap_len = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap_len) @(negedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= k;
        request_bytes <= want[15:0];
        address       <= addr[15:0];
        do
            @(posedge clk);
        while (in_stall);
        sb.note_item(k, want & 16'hFFFF, addr & 16'hFFFF);
    endtask

    task automatic pause_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic free_all_live();
        while (sb.live_q.size() > 0)
            send_item(KIND_FREE, $urandom_range(0, 65535),
                      sb.live_q[$urandom_range(0, sb.live_q.size() - 1)]);
    endtask

    initial
    begin
        int unsigned blk_a;
        int unsigned x2;
        int unsigned x3;
        int unsigned want;
        int unsigned addr;
        int          p;
        int          q;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_item(KIND_ALLOC, 0, 0);
        send_item(KIND_ALLOC, 65535, 0);
        send_item(KIND_ALLOC, 1, 65535);
        send_item(KIND_FREE, 0, 0);
        send_item(KIND_FREE, 0, 65535);
        send_item(KIND_FREE, 65535, 20);
        send_item(KIND_ALLOC, 100, 0);
        blk_a = sb.last_grant;
        send_item(KIND_ALLOC, 8, 0);
        send_item(KIND_FREE, 0, blk_a);
        send_item(KIND_FREE, 0, blk_a);
        send_item(KIND_ALLOC, 96, 0);
        send_item(KIND_ALLOC, 104, 0);
        send_item(KIND_FREE, 0, 16);
        send_item(KIND_ALLOC, 0, 0);
        send_item(KIND_ALLOC, sb.pick_free_len(), 0);
        send_item(KIND_ALLOC, 0, 0);
        // free the first block and a middle one, so a later free merges on both sides
        x3 = sb.live_q[3];
        x2 = sb.live_q[2];
        send_item(KIND_FREE, 0, x3);
        send_item(KIND_FREE, 0, x2);
        while (sb.live_q.size() > 0)
            send_item(KIND_FREE, 0, sb.live_q[0]);

        pause_until_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - QUIET_ITEMS)
            begin
                sender_idle_on = 1'b0;
                sink_idle_on   = 1'b0;
            end
            if (i % DRAIN_EVERY == DRAIN_EVERY - 1)
            begin
                pause_until_drained();
                free_all_live();
            end
            p = $urandom_range(0, 99);
            q = $urandom_range(0, 99);
            if (sb.live_q.size() == 0 || (sb.live_q.size() < LIVE_CAP && p < 55))
            begin
                if (q < 55)
                    want = $urandom_range(0, 64);
                else if (q < 80)
                    want = $urandom_range(65, 1024);
                else if (q < 90)
                    want = $urandom_range(1025, 8192);
                else if (q < 95)
                    want = $urandom_range(0, 65535);
                else
                    want = sb.pick_free_len();
                send_item(KIND_ALLOC, want, $urandom_range(0, 65535));
            end
            else
            begin
                if (q < 80)
                    addr = sb.live_q[$urandom_range(0, sb.live_q.size() - 1)];
                else if (q < 88)
                    addr = $urandom_range(0, 65535);
                else if (q < 94)
                    addr = (sb.live_q[$urandom_range(0, sb.live_q.size() - 1)]
                            + 8 * $urandom_range(1, 4)) & 16'hFFFF;
                else
                    addr = sb.last_freed;
                send_item(KIND_FREE, $urandom_range(0, 65535), addr);
            end
        end

        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("ran %0d allocates (%0d out of memory) and %0d frees (%0d bad address, %0d merges)",
                 sb.n_alloc, sb.n_nomem, sb.n_free, sb.n_bad, sb.n_merge);
        $display("%0d results checked in %0d cycles, %0d mismatches",
                 sb.checked, cycle_count, sb.errors);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
